FILE: hw/rtl/phdm_pkg.sv
// Shared types and constants for the pixel hit digitizer with merging.
// Used by phdm_divider, phdm_table and pixel_hit_digitizer_merge.
`timescale 1ns / 1ps
`default_nettype none
package phdm_pkg;

  localparam int unsigned KEY_W    = 52;
  localparam int unsigned POINT_W  = 16;
  localparam int unsigned CHARGE_W = 16;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_PITCH_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FE_COLS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FE_ROWS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FE_STRIDE = 3'd4;

  localparam logic CMD_HIT   = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // Divider handshake
  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage
`default_nettype wire

FILE: hw/rtl/pixel_hit_digitizer_merge.sv
// Pixel hit digitizer with per-event merging of fired pixels.
// Hit item: four divider runs in turn, then a search that compares one stored entry per cycle
//   until a match or the end of the table; the next item is taken after the search.
// Flush item: entries are read from the table and sent as one result per entry (one for an
//   empty table), one result per cycle while the output is taken.
// One item in work at a time. Synchronous active-low reset empties the table.
`timescale 1ns / 1ps
`default_nettype none
module pixel_hit_digitizer_merge #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_we,
  input  wire  [phdm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire  [phdm_pkg::CFG_W-1:0]     cfg_wdata,
  input  wire         in_tvalid,
  output logic        in_tready,
  // tuser: command
  input  wire         in_tuser,
  // tdata: point_index, detector_id, local_x, local_y, zero pad
  input  wire  [79:0] in_tdata,
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic        out_tlast,
  // tuser: valid_res
  output logic        out_tuser,
  // tdata: first_point, sensor_id, frontend_id, pixel_column, pixel_row, charge,
  //   overflow, zero pad
  output logic [87:0] out_tdata
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_DIVX  = 7'b0000010,
    ST_DIVY  = 7'b0000100,
    ST_DIVC  = 7'b0001000,
    ST_DIVR  = 7'b0010000,
    ST_SRCH  = 7'b0100000,
    ST_FLUSH = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [15:0] pitch_x_r, pitch_y_r;
  logic [9:0]  fe_cols_r, fe_rows_r;
  logic [7:0]  stride_r;

  logic [15:0] point_r, det_r;
  logic [19:0] ly_r, gcol_r;
  logic [9:0]  col_r;
  logic [15:0] fecol_r;
  logic [51:0] key_r;
  logic [CW-1:0] count_r;
  logic        ovf_r;
  logic [CW-1:0] idx_r;   // address issued last cycle
  logic        rvld_r;    // read data valid for idx_r

  // Output register
  logic        ovalid_r, olast_r, ores_r;
  logic [87:0] odata_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pitch_x_r <= 16'd100;
      pitch_y_r <= 16'd100;
      fe_cols_r <= 10'd128;
      fe_rows_r <= 10'd128;
      stride_r  <= 8'd8;
    end else if (cfg_we) begin
      unique case (cfg_index)
        phdm_pkg::REG_PITCH_X:   pitch_x_r <= cfg_wdata;
        phdm_pkg::REG_PITCH_Y:   pitch_y_r <= cfg_wdata;
        phdm_pkg::REG_FE_COLS:   fe_cols_r <= cfg_wdata[9:0];
        phdm_pkg::REG_FE_ROWS:   fe_rows_r <= cfg_wdata[9:0];
        phdm_pkg::REG_FE_STRIDE: stride_r  <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Shared divider
  phdm_pkg::div_ctl_t div_ctl;
  phdm_pkg::div_sts_t div_sts;
  logic [19:0] div_num, div_q;
  logic [15:0] div_den, div_rem;

  phdm_divider #(.NUM_W(20), .DEN_W(16)) u_div (
    .clk(clk), .rst_n(rst_n), .ctl(div_ctl), .numer(div_num), .denom(div_den),
    .sts(div_sts), .quot(div_q), .rem(div_rem)
  );

  // Table
  logic [AW-1:0] rd_addr, wr_addr;
  logic [51:0]   rd_key;
  logic [15:0]   rd_point, rd_charge, wr_charge;
  logic          wr_en, wr_full;

  phdm_table #(.DEPTH(TABLE_DEPTH)) u_tbl (
    .clk(clk), .rd_addr(rd_addr), .rd_key(rd_key), .rd_point(rd_point),
    .rd_charge(rd_charge), .wr_en(wr_en), .wr_full(wr_full), .wr_addr(wr_addr),
    .wr_key(key_r), .wr_point(point_r), .wr_charge(wr_charge)
  );

  logic        in_acc, out_free;
  logic [CW-1:0] idx_nxt;
  logic        rvld_nxt;
  logic [15:0] feid;
  logic [23:0] fe_prod;

  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !ovalid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign fe_prod  = fecol_r * stride_r;
  assign feid     = 16'd1 + fe_prod[15:0] + div_q[15:0];

  always_comb begin
    state_nxt = state_r;
    div_ctl.start = 1'b0;
    div_num = in_tdata[51:32];
    div_den = pitch_x_r;
    idx_nxt = idx_r;
    rvld_nxt = 1'b0;
    wr_en = 1'b0;
    wr_full = 1'b0;
    wr_addr = count_r[AW-1:0];
    wr_charge = 16'd1;
    rd_addr = idx_r[AW-1:0];
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          idx_nxt = '0;
          if (in_tuser == phdm_pkg::CMD_FLUSH) begin
            state_nxt = ST_FLUSH;
          end else begin
            div_ctl.start = 1'b1;
            state_nxt = ST_DIVX;
          end
        end
      end
      ST_DIVX: begin
        div_num = ly_r;
        div_den = pitch_y_r;
        if (div_sts.done) begin
          div_ctl.start = 1'b1;
          state_nxt = ST_DIVY;
        end
      end
      ST_DIVY: begin
        div_num = gcol_r;
        div_den = {6'd0, fe_cols_r};
        if (div_sts.done) begin
          div_ctl.start = 1'b1;
          state_nxt = ST_DIVC;
        end
      end
      ST_DIVC: begin
        div_num = ly_r;
        div_den = {6'd0, fe_rows_r};
        if (div_sts.done) begin
          div_ctl.start = 1'b1;
          state_nxt = ST_DIVR;
        end
      end
      ST_DIVR: begin
        if (div_sts.done) begin
          idx_nxt = '0;
          rd_addr = '0;
          rvld_nxt = (count_r != '0);
          state_nxt = ST_SRCH;
        end
      end
      ST_SRCH: begin
        // Compare entry idx_r; issue next read
        if (rvld_r && rd_key == key_r) begin
          wr_en = 1'b1;
          wr_addr = idx_r[AW-1:0];
          wr_charge = (rd_charge == 16'hFFFF) ? rd_charge : rd_charge + 16'd1;
          state_nxt = ST_IDLE;
        end else if (!rvld_r || idx_r + CW'(1) >= count_r) begin
          if (count_r < CW'(TABLE_DEPTH)) begin
            wr_en = 1'b1;
            wr_full = 1'b1;
          end
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt = idx_r + CW'(1);
          rd_addr = idx_nxt[AW-1:0];
          rvld_nxt = 1'b1;
        end
      end
      ST_FLUSH: begin
        // rvld_r marks read data for idx_r pending in the table output
        if (count_r == '0) begin
          if (out_free) state_nxt = ST_IDLE;
        end else if (!rvld_r) begin
          rd_addr = idx_r[AW-1:0];
          rvld_nxt = 1'b1;
        end else if (out_free) begin
          if (idx_r + CW'(1) == count_r) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r + CW'(1);
            rd_addr = idx_nxt[AW-1:0];
            rvld_nxt = 1'b1;
          end
        end else begin
          rvld_nxt = 1'b1;
          rd_addr = idx_r[AW-1:0];
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  logic flush_emit;
  assign flush_emit = (state_r == ST_FLUSH) && out_free &&
                      ((count_r == '0) || rvld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      count_r  <= '0;
      ovf_r    <= 1'b0;
      rvld_r   <= 1'b0;
      idx_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rvld_r  <= rvld_nxt;
      idx_r   <= idx_nxt;
      if (state_r == ST_SRCH && state_nxt == ST_IDLE && !wr_en) ovf_r <= 1'b1;
      if (wr_en && wr_full) count_r <= count_r + CW'(1);
      if (flush_emit) ovalid_r <= 1'b1;
      else if (out_tready) ovalid_r <= 1'b0;
      if (state_r == ST_FLUSH && state_nxt == ST_IDLE) begin
        count_r <= '0;
        ovf_r   <= 1'b0;
      end
    end
    // Capture operands and quotients
    if (in_acc) begin
      point_r <= in_tdata[15:0];
      det_r   <= in_tdata[31:16];
      ly_r    <= in_tdata[71:52];
    end
    if (state_r == ST_DIVX && div_sts.done) gcol_r <= div_q;
    if (state_r == ST_DIVY && div_sts.done) ly_r <= div_q;
    if (state_r == ST_DIVC && div_sts.done) begin
      fecol_r <= div_q[15:0];
      col_r   <= div_rem[9:0];
    end
    if (state_r == ST_DIVR && div_sts.done)
      key_r <= {det_r, feid, col_r, div_rem[9:0]};
    if (flush_emit) begin
      ores_r  <= (count_r != '0);
      olast_r <= (count_r == '0) || (idx_r + CW'(1) == count_r);
      if (count_r == '0)
        odata_r <= {3'd0, ovf_r, 84'd0};
      else
        odata_r <= {3'd0, ovf_r, rd_charge, rd_key[9:0], rd_key[19:10],
                    rd_key[35:20], rd_key[51:36], rd_point};
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tlast  = olast_r;
  assign out_tuser  = ores_r;
  assign out_tdata  = odata_r;

`ifndef ASSERT_OFF
  // Table count never exceeds depth
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_DEPTH)) else $error("entry count above depth");
  // No input accepted while a hit or flush is in work
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_tready) else $error("ready while busy");
  // After a flush completes the table is empty
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH && state_nxt == ST_IDLE) |=> (count_r == '0 && !ovf_r))
    else $error("table not cleared after flush");
`endif

endmodule
`default_nettype wire

FILE: hw/rtl/phdm_divider.sv
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on phdm_pkg for the control and status structs.
`timescale 1ns / 1ps
`default_nettype none
module phdm_divider #(
  parameter int unsigned NUM_W = 20,
  parameter int unsigned DEN_W = 16
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  phdm_pkg::div_ctl_t       ctl,
  input  wire  [NUM_W-1:0]         numer,
  input  wire  [DEN_W-1:0]         denom,
  output phdm_pkg::div_sts_t       sts,
  output logic [NUM_W-1:0]         quot,
  output logic [DEN_W-1:0]         rem
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] q_r, q_nxt;
  logic [DEN_W:0]   r_r, r_nxt;
  logic [DEN_W-1:0] d_r, d_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   trial;

  always_comb begin
    q_nxt    = q_r;
    r_nxt    = r_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {r_r[DEN_W-1:0], q_r[NUM_W-1]};
    if (ctl.start) begin
      // Load operands; zero divisor acts as one
      q_nxt    = numer;
      r_nxt    = '0;
      d_nxt    = (denom == '0) ? DEN_W'(1) : denom;
      cnt_nxt  = CNT_W'(NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // Shift in one numerator bit, subtract when it fits
      if (trial >= {1'b0, d_r}) begin
        r_nxt = trial - {1'b0, d_r};
        q_nxt = {q_r[NUM_W-2:0], 1'b1};
      end else begin
        r_nxt = trial;
        q_nxt = {q_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r <= q_nxt;
    r_r <= r_nxt;
    d_r <= d_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quot     = q_r;
  assign rem      = r_r[DEN_W-1:0];

endmodule
`default_nettype wire

FILE: hw/rtl/phdm_table.sv
// Fired-pixel table: key, first point and charge memories, registered read.
// Depends on phdm_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none
module phdm_table #(
  parameter int unsigned DEPTH = 64
) (
  input  wire                                       clk,
  input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [phdm_pkg::KEY_W-1:0]                 rd_key,
  output logic [phdm_pkg::POINT_W-1:0]               rd_point,
  output logic [phdm_pkg::CHARGE_W-1:0]              rd_charge,
  input  wire                                       wr_en,
  input  wire                                       wr_full,
  input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire  [phdm_pkg::KEY_W-1:0]                 wr_key,
  input  wire  [phdm_pkg::POINT_W-1:0]               wr_point,
  input  wire  [phdm_pkg::CHARGE_W-1:0]              wr_charge
);

  logic [phdm_pkg::KEY_W-1:0]    key_mem    [DEPTH];
  logic [phdm_pkg::POINT_W-1:0]  point_mem  [DEPTH];
  logic [phdm_pkg::CHARGE_W-1:0] charge_mem [DEPTH];

  // Write charge on every write; key and point only on append
  always_ff @(posedge clk) begin
    if (wr_en) begin
      charge_mem[wr_addr] <= wr_charge;
      if (wr_full) begin
        key_mem[wr_addr]   <= wr_key;
        point_mem[wr_addr] <= wr_point;
      end
    end
    rd_key    <= key_mem[rd_addr];
    rd_point  <= point_mem[rd_addr];
    rd_charge <= charge_mem[rd_addr];
  end

endmodule
`default_nettype wire

FILE: sim/pixel_hit_digitizer_merge_test.sv
// Self-checking test of pixel_hit_digitizer_merge: hits and flushes, checked against
// a behavioral model of the pixel table. Depends on phdm_pkg and the RTL.
`timescale 1ns / 1ps
module pixel_hit_digitizer_merge_test;

  localparam int DEPTH = 64;
  localparam int LIMIT = 2000000;

  typedef struct packed {
    logic        vld;
    logic [15:0] first;
    logic [15:0] sensor;
    logic [15:0] fe;
    logic [9:0]  col;
    logic [9:0]  row;
    logic [15:0] chg;
    logic        ovf;
    logic        lst;
  } pixel_t;

  typedef struct {
    logic        cmd;
    logic [15:0] point;
    logic [15:0] det;
    logic [19:0] lx;
    logic [19:0] ly;
    logic        chk;
    pixel_t      exp_pix;
  } row_t;

  logic clk = 0, rst_n = 0;
  logic cfg_we = 0;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_wdata = '0;
  logic in_tvalid = 0, in_tready, in_tuser = 0;
  logic [79:0] in_tdata = '0;
  logic out_tvalid, out_tready = 0, out_tlast, out_tuser;
  logic [87:0] out_tdata;

  pixel_hit_digitizer_merge i_dut (.*);

  // model state
  logic [15:0] m_px = 100, m_py = 100;
  logic [9:0]  m_fc = 128, m_fr = 128;
  logic [7:0]  m_stride = 8;
  logic [51:0] tbl_key[DEPTH];
  logic [15:0] tbl_first[DEPTH];
  logic [15:0] tbl_chg[DEPTH];
  int          tbl_count = 0;
  logic        tbl_ovf = 0;

  pixel_t pending_pixels[$];
  int errors = 0;
  int cycles = 0;
  int snd_idle = 36, rcv_idle = 81;
  logic hold_off = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // timeout watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [31:0] nz(input logic [31:0] v);
    return (v == 0) ? 32'd1 : v;
  endfunction

  // merge one hit into the model table
  task automatic merge_hit(input logic [15:0] pt, input logic [15:0] det,
                           input logic [19:0] lx, input logic [19:0] ly);
    logic [31:0] gc, gr, fcol, frow, c, r, id;
    logic [51:0] key;
    gc = lx / nz(m_px);
    gr = ly / nz(m_py);
    fcol = gc / nz(m_fc); c = gc % nz(m_fc);
    frow = gr / nz(m_fr); r = gr % nz(m_fr);
    id = (1 + fcol * m_stride + frow) & 32'hFFFF;
    key = {det, id[15:0], c[9:0], r[9:0]};
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_key[i] == key) begin
        if (tbl_chg[i] != 16'hFFFF) tbl_chg[i]++;
        return;
      end
    end
    if (tbl_count >= DEPTH) begin
      tbl_ovf = 1;
      return;
    end
    tbl_key[tbl_count] = key;
    tbl_first[tbl_count] = pt;
    tbl_chg[tbl_count] = 1;
    tbl_count++;
  endtask

  // emit the model table as expected pixels, then clear it
  task automatic flush_table(output pixel_t first_pix);
    pixel_t p;
    if (tbl_count == 0) begin
      p = '0; p.ovf = tbl_ovf; p.lst = 1;
      pending_pixels.push_back(p);
      first_pix = p;
    end else begin
      for (int k = 0; k < tbl_count; k++) begin
        p.vld = 1; p.first = tbl_first[k];
        {p.sensor, p.fe, p.col, p.row} = tbl_key[k];
        p.chg = tbl_chg[k]; p.ovf = tbl_ovf; p.lst = (k == tbl_count - 1);
        pending_pixels.push_back(p);
        if (k == 0) first_pix = p;
      end
    end
    tbl_count = 0;
    tbl_ovf = 0;
  endtask

  // drive one item and record its expectations at acceptance
  task automatic send_item(input row_t it);
    pixel_t fp;
    while ($urandom_range(99) < snd_idle) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= it.cmd;
    in_tdata <= {8'h00, it.ly, it.lx, it.det, it.point};
    do @(posedge clk); while (!in_tready);
    if (it.cmd == phdm_pkg::CMD_HIT) merge_hit(it.point, it.det, it.lx, it.ly);
    else begin
      flush_table(fp);
      if (it.chk && fp !== it.exp_pix) begin
        $display("%0t directed flush mismatch exp %h act %h", $time, it.exp_pix, fp);
        errors++;
      end
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_we <= 1; cfg_index <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      phdm_pkg::REG_PITCH_X:   m_px = val;
      phdm_pkg::REG_PITCH_Y:   m_py = val;
      phdm_pkg::REG_FE_COLS:   m_fc = val[9:0];
      phdm_pkg::REG_FE_ROWS:   m_fr = val[9:0];
      phdm_pkg::REG_FE_STRIDE: m_stride = val[7:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // wait until all results are in, plus a margin for a hit still in work
  task automatic drain;
    in_tvalid <= 0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic row_t mk(input logic cmd, input logic [15:0] pt,
                              input logic [15:0] det, input logic [19:0] lx,
                              input logic [19:0] ly);
    row_t r;
    r.cmd = cmd; r.point = pt; r.det = det; r.lx = lx; r.ly = ly;
    r.chk = 0; r.exp_pix = '0;
    return r;
  endfunction

  task automatic random_event(input int hits, input logic spread);
    row_t r;
    for (int h = 0; h < hits; h++) begin
      r = mk(phdm_pkg::CMD_HIT, 16'($urandom),
             spread ? 16'($urandom) : 16'($urandom_range(3)),
             spread ? 20'($urandom_range(20'hFFFFF)) : 20'($urandom_range(400)),
             spread ? 20'($urandom_range(20'hFFFFF)) : 20'($urandom_range(400)));
      send_item(r);
    end
    send_item(mk(phdm_pkg::CMD_FLUSH, 16'($urandom), 16'($urandom), 20'($urandom),
                 20'($urandom)));
  endtask

  // receiver: random stalls plus a forced hold-off
  always @(posedge clk) begin
    if (!rst_n || hold_off) out_tready <= 0;
    else out_tready <= ($urandom_range(99) >= rcv_idle);
  end

  // compare accepted results with the oldest expectation
  always @(posedge clk) begin
    pixel_t act, ex;
    if (rst_n && out_tvalid && out_tready) begin
      act.vld    = out_tuser;
      act.first  = out_tdata[15:0];
      act.sensor = out_tdata[31:16];
      act.fe     = out_tdata[47:32];
      act.col    = out_tdata[57:48];
      act.row    = out_tdata[67:58];
      act.chg    = out_tdata[83:68];
      act.ovf    = out_tdata[84];
      act.lst    = out_tlast;
      if (pending_pixels.size() == 0) begin
        $display("%0t unexpected result act %h", $time, act);
        errors++;
      end else begin
        ex = pending_pixels.pop_front();
        if (act !== ex) begin
          $display("%0t result mismatch exp %h act %h", $time, ex, act);
          errors++;
        end
      end
    end
  end

  row_t dir_rows[$];
  initial begin
    row_t r;
    pixel_t e;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: empty flush after reset, extremes, merge, saturation-free repeat
    r = mk(phdm_pkg::CMD_FLUSH, 0, 0, 0, 0); r.chk = 1; e = '0; e.lst = 1; r.exp_pix = e;
    dir_rows.push_back(r);
    r = mk(phdm_pkg::CMD_HIT, 16'hFFFF, 16'hFFFF, 20'hFFFFF, 20'hFFFFF);
    dir_rows.push_back(r);
    dir_rows.push_back(mk(phdm_pkg::CMD_HIT, 0, 0, 0, 0));
    dir_rows.push_back(mk(phdm_pkg::CMD_HIT, 5, 0, 99, 99));
    dir_rows.push_back(mk(phdm_pkg::CMD_HIT, 6, 0, 100, 0));
    dir_rows.push_back(mk(phdm_pkg::CMD_HIT, 7, 16'hFFFF, 20'hFFFFF, 20'hFFFFF));
    dir_rows.push_back(mk(phdm_pkg::CMD_FLUSH, 16'hFFFF, 16'hFFFF, 20'hFFFFF, 20'hFFFFF));
    r = mk(phdm_pkg::CMD_HIT, 1, 1, 0, 0);
    r.chk = 0;
    dir_rows.push_back(r);
    r = mk(phdm_pkg::CMD_FLUSH, 0, 0, 0, 0); r.chk = 1;
    e = '0; e.vld = 1; e.first = 1; e.sensor = 1; e.fe = 1; e.chg = 1; e.lst = 1;
    r.exp_pix = e;
    dir_rows.push_back(r);
    foreach (dir_rows[i]) send_item(dir_rows[i]);
    drain();

    // table overflow: 66 distinct pixels, plus a merge into a stored one
    for (int i = 0; i < 66; i++)
      send_item(mk(phdm_pkg::CMD_HIT, 16'(i), 16'h00AA, 20'(i * 100), 0));
    send_item(mk(phdm_pkg::CMD_HIT, 99, 16'h00AA, 0, 0));
    send_item(mk(phdm_pkg::CMD_FLUSH, 0, 0, 0, 0));
    r = mk(phdm_pkg::CMD_FLUSH, 0, 0, 0, 0); r.chk = 1; e = '0; e.lst = 1; r.exp_pix = e;
    send_item(r);
    drain();

    // zero divisors and zero stride
    write_reg(phdm_pkg::REG_PITCH_X, 0); write_reg(phdm_pkg::REG_PITCH_Y, 0);
    write_reg(phdm_pkg::REG_FE_COLS, 0); write_reg(phdm_pkg::REG_FE_ROWS, 0);
    write_reg(phdm_pkg::REG_FE_STRIDE, 0);
    random_event(4, 0);
    drain();

    // maximum settings
    write_reg(phdm_pkg::REG_PITCH_X, 16'hFFFF); write_reg(phdm_pkg::REG_PITCH_Y, 16'hFFFF);
    write_reg(phdm_pkg::REG_FE_COLS, 1023); write_reg(phdm_pkg::REG_FE_ROWS, 1023);
    write_reg(phdm_pkg::REG_FE_STRIDE, 255);
    random_event(4, 1);
    drain();

    // random phases with various settings and idling patterns
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin snd_idle = 81; rcv_idle = 36; end
      if (ph == 2) begin snd_idle = 0; rcv_idle = 0; end
      write_reg(phdm_pkg::REG_PITCH_X, 16'($urandom_range(1, 40)));
      write_reg(phdm_pkg::REG_PITCH_Y, 16'($urandom_range(1, 40)));
      write_reg(phdm_pkg::REG_FE_COLS, 16'($urandom_range(1, 12)));
      write_reg(phdm_pkg::REG_FE_ROWS, 16'($urandom_range(1, 12)));
      write_reg(phdm_pkg::REG_FE_STRIDE, 16'($urandom_range(0, 255)));
      for (int ev = 0; ev < 6; ev++) random_event($urandom_range(0, 7), ev == 5);
      drain();
    end

    // long receiver hold-off while the sender keeps offering items
    hold_off = 1;
    fork
      begin
        repeat (3000) @(posedge clk);
        hold_off = 0;
      end
      begin
        for (int ev = 0; ev < 3; ev++) random_event(5, 0);
      end
    join
    drain();

    if (errors == 0 && pending_pixels.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

FILE: pixel_hit_digitizer_merge.f
hw/rtl/phdm_pkg.sv
hw/rtl/phdm_divider.sv
hw/rtl/phdm_table.sv
hw/rtl/pixel_hit_digitizer_merge.sv
sim/pixel_hit_digitizer_merge_test.sv
